### design/tvs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvs_pkg
// Shared constants, request layout and controller/datapath command types
// for the trilinear volume sampler.
// ---------------------------------------------------------------------------
package tvs_pkg;

  localparam int MAX_DIM   = 16;
  localparam int FRAC_BITS = 8;

  localparam int COORD_W  = 12;
  localparam int VAL_W    = 16;
  localparam int SIZE_W   = 5;
  localparam int IDX_W    = $clog2(MAX_DIM);
  localparam int INT_W    = COORD_W - FRAC_BITS;
  localparam int ADDR_W   = 3 * IDX_W;
  localparam int DEPTH    = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int SYZ_W    = 2 * IDX_W + 1;
  localparam int PROD_W   = VAL_W + 1 + FRAC_BITS + 1;
  localparam int CFG_IDX_W = 2;

  // Request tdata layout, lowest bit first
  localparam int POSX_LSB  = 0;
  localparam int POSY_LSB  = POSX_LSB + COORD_W;
  localparam int POSZ_LSB  = POSY_LSB + COORD_W;
  localparam int VAL_LSB   = POSZ_LSB + COORD_W;
  localparam int IN_DATA_W = ((VAL_LSB + VAL_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

  // Request kinds carried on tuser
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Blend operand sources
  localparam logic [1:0] MS_CORNER = 2'd0;
  localparam logic [1:0] MS_XY0    = 2'd1;
  localparam logic [1:0] MS_XY1    = 2'd2;
  localparam logic [1:0] MS_Z      = 2'd3;

  // Blend result destinations
  localparam logic [2:0] SD_NONE = 3'd0;
  localparam logic [2:0] SD_A0   = 3'd1;
  localparam logic [2:0] SD_B0   = 3'd2;
  localparam logic [2:0] SD_A1   = 3'd3;
  localparam logic [2:0] SD_B1   = 3'd4;
  localparam logic [2:0] SD_NEAR = 3'd5;
  localparam logic [2:0] SD_FAR  = 3'd6;
  localparam logic [2:0] SD_OUT  = 3'd7;

  typedef struct packed {
    logic       wr_en;
    logic       load;
    logic [2:0] corner;
    logic       hold_en;
    logic       mul_en;
    logic [1:0] mul_src;
    logic [2:0] sum_dst;
  } tvs_cmd_t;

  typedef struct packed {
    logic out_busy;
  } tvs_status_t;

  // Size in use: zero acts as one, anything above the store acts as MAX_DIM
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_W'(MAX_DIM)) begin
      r = SIZE_W'(MAX_DIM);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

### design/tvs_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvs_ctrl
// Request acceptance and the fourteen-step sample sequencer: corner reads,
// blend operand selection and result destinations.
// ---------------------------------------------------------------------------
module tvs_ctrl
  import tvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tuser,
  output logic        in_tready,
  input  tvs_status_t status,
  output tvs_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SAMP = 1'b1;

  localparam logic [3:0] STEP_RD0      = 4'd0;
  localparam logic [3:0] STEP_HOLD000  = 4'd1;
  localparam logic [3:0] STEP_MUL_X00  = 4'd2;
  localparam logic [3:0] STEP_HOLD010  = 4'd3;
  localparam logic [3:0] STEP_MUL_X10  = 4'd4;
  localparam logic [3:0] STEP_HOLD001  = 4'd5;
  localparam logic [3:0] STEP_MUL_X01  = 4'd6;
  localparam logic [3:0] STEP_HOLD011  = 4'd7;
  localparam logic [3:0] STEP_MUL_X11  = 4'd8;
  localparam logic [3:0] STEP_SUM_B1   = 4'd9;
  localparam logic [3:0] STEP_MUL_Y1   = 4'd10;
  localparam logic [3:0] STEP_SUM_FAR  = 4'd11;
  localparam logic [3:0] STEP_MUL_Z    = 4'd12;
  localparam logic [3:0] STEP_LAST     = 4'd13;

  logic       state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic       accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    cmd         = '0;
    cmd.mul_src = MS_CORNER;
    cmd.sum_dst = SD_NONE;
    cmd.corner  = step_r[2:0];
    cmd.wr_en   = accept & (in_tuser == MODE_WRITE);
    cmd.load    = accept & (in_tuser == MODE_SAMPLE);
    if (state_r == ST_SAMP) begin
      unique case (step_r)
        STEP_RD0: begin
        end
        STEP_HOLD000: cmd.hold_en = 1'b1;
        STEP_MUL_X00: cmd.mul_en  = 1'b1;
        STEP_HOLD010: begin
          cmd.hold_en = 1'b1;
          cmd.sum_dst = SD_A0;
        end
        STEP_MUL_X10: cmd.mul_en = 1'b1;
        STEP_HOLD001: begin
          cmd.hold_en = 1'b1;
          cmd.sum_dst = SD_B0;
        end
        STEP_MUL_X01: cmd.mul_en = 1'b1;
        STEP_HOLD011: begin
          cmd.hold_en = 1'b1;
          cmd.sum_dst = SD_A1;
          cmd.mul_en  = 1'b1;
          cmd.mul_src = MS_XY0;
        end
        STEP_MUL_X11: begin
          cmd.mul_en  = 1'b1;
          cmd.sum_dst = SD_NEAR;
        end
        STEP_SUM_B1: cmd.sum_dst = SD_B1;
        STEP_MUL_Y1: begin
          cmd.mul_en  = 1'b1;
          cmd.mul_src = MS_XY1;
        end
        STEP_SUM_FAR: cmd.sum_dst = SD_FAR;
        STEP_MUL_Z: begin
          cmd.mul_en  = 1'b1;
          cmd.mul_src = MS_Z;
        end
        STEP_LAST: begin
          // hold the final sum until the output register is free
          if (!status.out_busy) begin
            cmd.sum_dst = SD_OUT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = STEP_RD0;
        if (cmd.load) begin
          state_nxt = ST_SAMP;
        end
      end
      ST_SAMP: begin
        if (step_r == STEP_LAST) begin
          if (!status.out_busy) begin
            state_nxt = ST_IDLE;
            step_nxt  = STEP_RD0;
          end
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = STEP_RD0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STEP_RD0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tuser == MODE_SAMPLE) |=> (state_r == ST_SAMP && step_r == STEP_RD0))
    else $error("sample request did not start the sequencer");

  a_step_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SAMP && step_r != STEP_LAST) |=>
      (state_r == ST_SAMP && step_r == $past(step_r) + 4'd1))
    else $error("sequencer skipped or held a step");

  a_finish_on_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SAMP && step_r == STEP_LAST && !status.out_busy) |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle after delivering");

endmodule

### design/tvs_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tvs_datapath
// Size registers, voxel memory with address generation, shared blend unit
// (subtract, multiply, floor shift, add) and the output register.
// ---------------------------------------------------------------------------
module tvs_datapath
  import tvs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  tvs_cmd_t             cmd,
  output tvs_status_t          status,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [VAL_W-1:0]     out_tdata
);

  // Size registers and the y*z plane size
  logic [SIZE_W-1:0] sx_r, sy_r, sz_r;
  logic [SIZE_W-1:0] sx_nxt, sy_nxt, sz_nxt;
  logic [SYZ_W-1:0]  syz_r, syz_nxt;
  logic [2*SIZE_W-1:0] syz_full;
  logic              cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_comb begin
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    sz_nxt = sz_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE_X: sx_nxt = eff_size(cfg_data);
        CFG_SIZE_Y: sy_nxt = eff_size(cfg_data);
        CFG_SIZE_Z: sz_nxt = eff_size(cfg_data);
        default: begin
        end
      endcase
    end
    syz_full = sy_nxt * sz_nxt;
    syz_nxt  = syz_full[SYZ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r  <= SIZE_W'(MAX_DIM);
      sy_r  <= SIZE_W'(MAX_DIM);
      sz_r  <= SIZE_W'(MAX_DIM);
      syz_r <= SYZ_W'(MAX_DIM * MAX_DIM);
    end else begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sz_r  <= sz_nxt;
      syz_r <= syz_nxt;
    end
  end

  // Request fields
  logic [COORD_W-1:0] pos_x, pos_y, pos_z;
  logic [VAL_W-1:0]   wr_value;
  logic [INT_W-1:0]   ix, iy, iz;

  assign pos_x    = in_tdata[POSX_LSB +: COORD_W];
  assign pos_y    = in_tdata[POSY_LSB +: COORD_W];
  assign pos_z    = in_tdata[POSZ_LSB +: COORD_W];
  assign wr_value = in_tdata[VAL_LSB +: VAL_W];
  assign ix       = pos_x[COORD_W-1:FRAC_BITS];
  assign iy       = pos_y[COORD_W-1:FRAC_BITS];
  assign iz       = pos_z[COORD_W-1:FRAC_BITS];

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [SIZE_W-1:0] i,
                                                 input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] last;
    last = n - SIZE_W'(1);
    return (i >= n) ? last[IDX_W-1:0] : i[IDX_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] voxel_addr(input logic [IDX_W-1:0]  x,
                                                   input logic [IDX_W-1:0]  y,
                                                   input logic [IDX_W-1:0]  z,
                                                   input logic [SYZ_W-1:0]  syz,
                                                   input logic [SIZE_W-1:0] sz);
    logic [IDX_W+SYZ_W-1:0] xp;
    logic [IDX_W+SIZE_W-1:0] yp;
    logic [IDX_W+SYZ_W-1:0] sum;
    xp  = x * syz;
    yp  = y * sz;
    sum = xp + (IDX_W + SYZ_W)'(yp) + (IDX_W + SYZ_W)'(z);
    return sum[ADDR_W-1:0];
  endfunction

  // Clamped corner indexes and fractions, latched at a sample request
  logic [IDX_W-1:0]     x0_r, x1_r, y0_r, y1_r, z0_r, z1_r;
  logic [IDX_W-1:0]     x0_nxt, y0_nxt, z0_nxt;
  logic [FRAC_BITS-1:0] fx_r, fy_r, fz_r;

  assign x0_nxt = clamp_idx(SIZE_W'(ix), sx_r);
  assign y0_nxt = clamp_idx(SIZE_W'(iy), sy_r);
  assign z0_nxt = clamp_idx(SIZE_W'(iz), sz_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r <= x0_nxt;
      y0_r <= y0_nxt;
      z0_r <= z0_nxt;
      x1_r <= clamp_idx(SIZE_W'(x0_nxt) + SIZE_W'(1), sx_r);
      y1_r <= clamp_idx(SIZE_W'(y0_nxt) + SIZE_W'(1), sy_r);
      z1_r <= clamp_idx(SIZE_W'(z0_nxt) + SIZE_W'(1), sz_r);
      fx_r <= pos_x[FRAC_BITS-1:0];
      fy_r <= pos_y[FRAC_BITS-1:0];
      fz_r <= pos_z[FRAC_BITS-1:0];
    end
  end

  // Voxel memory, single port, registered read
  logic [VAL_W-1:0]  voxel_mem [DEPTH];
  logic [VAL_W-1:0]  rdata_r;
  logic [ADDR_W-1:0] wr_addr, rd_addr, mem_addr;
  logic              in_range, mem_we;
  logic [IDX_W-1:0]  cx, cy, cz;

  // drop writes outside the sizes in use
  assign in_range = (SIZE_W'(ix) < sx_r) && (SIZE_W'(iy) < sy_r) && (SIZE_W'(iz) < sz_r);
  assign mem_we   = cmd.wr_en & in_range;
  assign wr_addr  = voxel_addr(ix[IDX_W-1:0], iy[IDX_W-1:0], iz[IDX_W-1:0], syz_r, sz_r);

  assign cx       = cmd.corner[0] ? x1_r : x0_r;
  assign cy       = cmd.corner[1] ? y1_r : y0_r;
  assign cz       = cmd.corner[2] ? z1_r : z0_r;
  assign rd_addr  = voxel_addr(cx, cy, cz, syz_r, sz_r);
  assign mem_addr = mem_we ? wr_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      voxel_mem[mem_addr] <= wr_value;
    end
    rdata_r <= voxel_mem[mem_addr];
  end

  // Blend unit: a + floor((b - a) * f / 2^FRAC_BITS), product registered
  logic [VAL_W-1:0]         hold_r, a0_r, b0_r, a1_r, b1_r, near_r, far_r;
  logic [VAL_W-1:0]         base_r, out_data_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt, prod_shr;
  logic [VAL_W-1:0]         op_a, op_b;
  logic [FRAC_BITS-1:0]     op_f;
  logic signed [VAL_W:0]    diff;
  logic [VAL_W+1:0]         blend_sum;
  logic [VAL_W-1:0]         blend_res;

  always_comb begin
    case (cmd.mul_src)
      MS_CORNER: begin
        op_a = hold_r;
        op_b = rdata_r;
        op_f = fx_r;
      end
      MS_XY0: begin
        op_a = a0_r;
        op_b = b0_r;
        op_f = fy_r;
      end
      MS_XY1: begin
        op_a = a1_r;
        op_b = b1_r;
        op_f = fy_r;
      end
      default: begin
        op_a = near_r;
        op_b = far_r;
        op_f = fz_r;
      end
    endcase
    diff     = $signed({op_b[VAL_W-1], op_b}) - $signed({op_a[VAL_W-1], op_a});
    prod_nxt = diff * $signed({1'b0, op_f});
  end

  assign prod_shr  = prod_r >>> FRAC_BITS;
  assign blend_sum = {{2{base_r[VAL_W-1]}}, base_r} + prod_shr[VAL_W+1:0];
  // the blend lies between its operands, so the low bits hold it exactly
  assign blend_res = blend_sum[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.hold_en) begin
      hold_r <= rdata_r;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
      base_r <= op_a;
    end
    case (cmd.sum_dst)
      SD_A0:   a0_r       <= blend_res;
      SD_B0:   b0_r       <= blend_res;
      SD_A1:   a1_r       <= blend_res;
      SD_B1:   b1_r       <= blend_res;
      SD_NEAR: near_r     <= blend_res;
      SD_FAR:  far_r      <= blend_res;
      SD_OUT:  out_data_r <= blend_res;
      default: begin
      end
    endcase
  end

  // Output register
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.sum_dst == SD_OUT) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign out_tdata       = out_data_r;
  assign status.out_busy = out_valid_r & ~out_tready;

  a_out_from_blend: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.sum_dst == SD_OUT))
    else $error("result raised without a final blend");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sum_dst == SD_OUT) |-> !status.out_busy)
    else $error("pending result overwritten");

endmodule

### design/trilinear_volume_sampler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trilinear_volume_sampler
// Voxel store of signed Q8.8 values sampled by trilinear interpolation.
// ---------------------------------------------------------------------------
// Requests arrive on the in_ stream. tuser is the mode: 0 writes value at the
// integer part of (pos_x, pos_y, pos_z), 1 samples at the fixed-point position.
// Writes outside the sizes in use are dropped; sample corners beyond the last
// voxel in use are clamped to it. Samples return one Q8.8 result on out_;
// writes return nothing.
// Back-to-back writes are accepted every cycle.
// A sample reads its eight corners one per cycle from the single-port voxel
// memory and blends them through one shared multiplier, so in_tready is low
// while a sample runs its steps and returns high in the same cycle that its
// result appears in the output register.
// If the receiver stalls, a finished result waits in the output register and
// writes continue; the next sample stops at its final step until it drains.
// The cfg_ channel writes size_x, size_y, size_z (indexes 0..2) and is always
// ready; write it only while the block is idle. Reset sets all sizes to 16
// and clears the handshake state; voxel contents are undefined until written.
// ---------------------------------------------------------------------------
module trilinear_volume_sampler
  import tvs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // pos_x [11:0], pos_y [23:12], pos_z [35:24], value [51:36], zero pad
  input  logic [IN_DATA_W-1:0] in_tdata,
  // mode [0]
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // sample [15:0]
  output logic [VAL_W-1:0]     out_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  tvs_cmd_t    cmd;
  tvs_status_t status;

  tvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tvs_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
